// File: hw/rtl/bitmap_scan_engine_unit_macros.svh
// Assertion macros for the bitmap scan engine.
`ifndef BITMAP_SCAN_ENGINE_UNIT_MACROS_SVH
`define BITMAP_SCAN_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BSE_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define BSE_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define BSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/bse_pkg.sv
`timescale 1ns / 1ps
package bse_pkg;
    localparam int MaxBitsDef  = 1024;
    localparam int WordBitsDef = 32;
    localparam int KindW  = 4;
    localparam int IdxW   = 10;
    localparam int CountW = 11;

    typedef enum logic [3:0] {
        K_SET = 4'd0, K_CLR = 4'd1, K_TGL = 4'd2, K_GET = 4'd3,
        K_FILL_RNG = 4'd4, K_CLR_RNG = 4'd5, K_FILL_ALL = 4'd6, K_CLR_ALL = 4'd7,
        K_FIRST_SET = 4'd8, K_FIRST_CLR = 4'd9, K_NEXT_SET = 4'd10, K_STATUS = 4'd11
    } t_kind;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [IdxW-1:0]  bit_index;
        logic [IdxW-1:0]  last_index;
    } t_cmd;

    typedef struct packed {
        logic            bit_value;
        logic            found;
        logic [IdxW-1:0] found_index;
        logic            any_set;
        logic            any_clear;
        logic            error;
    } t_res;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch command, reset scan pointer
        logic step;      // process one word
        logic trim;      // trim pass after count write
    } t_dp_ctl;

    // datapath -> controller
    typedef struct packed {
        logic last_word;
    } t_dp_sts;
endpackage

// File: hw/rtl/bse_if.sv
`timescale 1ns / 1ps
interface bse_cmd_if;
    logic          valid;
    logic          ready;
    bse_pkg::t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bse_res_if;
    logic          valid;
    logic          ready;
    bse_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/bse_ram.sv
`timescale 1ns / 1ps
module bse_ram #(
    parameter int Width = 32,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/bse_dp.sv
`timescale 1ns / 1ps
// Word-serial datapath. Word w is read in one cycle, modified and written in
// the next; a valid bit per word stands in for the reset clear.
module bse_dp #(
    parameter int MaxBits  = bse_pkg::MaxBitsDef,
    parameter int WordBits = bse_pkg::WordBitsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bse_pkg::t_dp_ctl              i_ctl,
    input  bse_pkg::t_cmd                 i_cmd,
    input  logic [bse_pkg::CountW-1:0]    i_count,
    input  logic                          i_clear_all,
    output bse_pkg::t_dp_sts              o_sts,
    output bse_pkg::t_res                 o_res
);
    localparam int WordCount = (MaxBits + WordBits - 1) / WordBits;
    localparam int WaW = (WordCount > 1) ? $clog2(WordCount) : 1;
    localparam int BoW = $clog2(WordBits);
    localparam int PosW = WaW + BoW;
    localparam int CntW = $clog2(MaxBits + 1) > bse_pkg::CountW ?
                          $clog2(MaxBits + 1) : bse_pkg::CountW;

    logic [WaW-1:0]      r_ptr, r_wptr;
    logic                r_wr_pend;
    logic [WordCount-1:0] r_vld;
    bse_pkg::t_cmd       r_cmd;
    logic                r_trim;
    logic [WordBits-1:0] w_rdata, w_word, w_new;
    logic [CntW-1:0]     w_live;
    logic [PosW-1:0]     w_first, w_last;
    logic                w_err;
    logic                r_value, r_found, r_any_set, r_any_clr;
    logic [bse_pkg::IdxW-1:0] r_where;

    // live count saturates at MaxBits
    always_comb begin
        if (CntW'(i_count) > CntW'(MaxBits)) w_live = CntW'(MaxBits);
        else                                 w_live = CntW'(i_count);
    end
    assign w_first = PosW'(r_cmd.bit_index);
    assign w_last  = PosW'(r_cmd.last_index);

    always_comb begin
        w_err = 1'b0;
        case (r_cmd.kind) inside
            bse_pkg::K_SET, bse_pkg::K_CLR, bse_pkg::K_TGL, bse_pkg::K_GET,
            bse_pkg::K_NEXT_SET:
                w_err = CntW'(r_cmd.bit_index) >= w_live;
            bse_pkg::K_FILL_RNG, bse_pkg::K_CLR_RNG:
                w_err = (CntW'(r_cmd.bit_index) >= w_live) ||
                        (CntW'(r_cmd.last_index) >= w_live) ||
                        (r_cmd.last_index < r_cmd.bit_index);
            bse_pkg::K_FILL_ALL, bse_pkg::K_CLR_ALL, bse_pkg::K_FIRST_SET,
            bse_pkg::K_FIRST_CLR, bse_pkg::K_STATUS:
                w_err = 1'b0;
            default: w_err = 1'b1;
        endcase
    end

    bse_ram #(.Width(WordBits), .Depth(WordCount)) u_ram (
        .i_clk  (i_clk),
        .i_we   (r_wr_pend),
        .i_waddr(r_wptr),
        .i_wdata(w_new),
        .i_raddr(r_ptr),
        .o_rdata(w_rdata)
    );

    // word under modification (read issued last cycle)
    assign w_word = r_vld[r_wptr] ? w_rdata : '0;

    // per-bit new value and scan over the modified word
    logic [WordBits-1:0] w_live_m;
    always_comb begin
        logic [PosW-1:0] p;
        w_new = w_word;
        for (int b = 0; b < WordBits; b++) begin
            p = {r_wptr, BoW'(b)};
            w_live_m[b] = CntW'(p) < w_live;
            if (r_trim) begin
                if (!w_live_m[b]) w_new[b] = 1'b0;
            end else if (!w_err) begin
                case (r_cmd.kind) inside
                    bse_pkg::K_SET: if (p == w_first) w_new[b] = 1'b1;
                    bse_pkg::K_CLR: if (p == w_first) w_new[b] = 1'b0;
                    bse_pkg::K_TGL: if (p == w_first) w_new[b] = ~w_word[b];
                    bse_pkg::K_FILL_RNG:
                        if (p >= w_first && p <= w_last) w_new[b] = 1'b1;
                    bse_pkg::K_CLR_RNG:
                        if (p >= w_first && p <= w_last) w_new[b] = 1'b0;
                    bse_pkg::K_FILL_ALL: if (w_live_m[b]) w_new[b] = 1'b1;
                    bse_pkg::K_CLR_ALL: w_new[b] = 1'b0;
                    default: w_new[b] = w_word[b];
                endcase
            end
        end
    end

    // scan matches within this word
    logic [WordBits-1:0] w_m_set, w_m_clr, w_m_want;
    logic                w_hit;
    logic [BoW-1:0]      w_hit_pos;
    always_comb begin
        logic [PosW-1:0] p;
        w_m_set = w_new & w_live_m;
        w_m_clr = ~w_new & w_live_m;
        for (int b = 0; b < WordBits; b++) begin
            p = {r_wptr, BoW'(b)};
            case (r_cmd.kind) inside
                bse_pkg::K_FIRST_SET: w_m_want[b] = w_m_set[b];
                bse_pkg::K_FIRST_CLR: w_m_want[b] = w_m_clr[b];
                bse_pkg::K_NEXT_SET:  w_m_want[b] = w_m_set[b] && (p > w_first);
                default:              w_m_want[b] = 1'b0;
            endcase
        end
        w_hit = |w_m_want;
        w_hit_pos = '0;
        for (int b = WordBits - 1; b >= 0; b--) begin
            if (w_m_want[b]) w_hit_pos = BoW'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_wr_pend <= 1'b0;
            r_trim    <= 1'b0;
        end else begin
            r_wr_pend <= i_ctl.step;
            if (i_ctl.load) r_trim <= i_ctl.trim;
            if (i_clear_all) r_vld <= '0;
            else if (r_wr_pend) r_vld[r_wptr] <= 1'b1;
        end
        if (i_ctl.load) begin
            r_cmd     <= i_cmd;
            r_ptr     <= '0;
            r_value   <= 1'b0;
            r_found   <= 1'b0;
            r_where   <= '0;
            r_any_set <= 1'b0;
            r_any_clr <= 1'b0;
        end else if (i_ctl.step) begin
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_ctl.step) r_wptr <= r_ptr;
        if (r_wr_pend && !r_trim) begin
            r_any_set <= r_any_set | (|w_m_set);
            r_any_clr <= r_any_clr | (|w_m_clr);
            if (w_hit && !r_found && !w_err) begin
                r_found <= 1'b1;
                r_where <= bse_pkg::IdxW'({r_wptr, w_hit_pos});
            end
            if (!w_err && r_cmd.kind <= bse_pkg::K_CLR_RNG &&
                r_wptr == w_first[PosW-1:BoW]) begin
                r_value <= w_new[w_first[BoW-1:0]];
            end
        end
    end

    assign o_sts.last_word = (r_ptr == WaW'(WordCount - 1));
    assign o_res.bit_value   = r_value;
    assign o_res.found       = r_found;
    assign o_res.found_index = r_where;
    assign o_res.any_set     = r_any_set;
    assign o_res.any_clear   = r_any_clr;
    assign o_res.error       = w_err;
endmodule

// File: hw/rtl/bse_ctrl.sv
`timescale 1ns / 1ps
module bse_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  logic               i_cfg_we,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    input  bse_pkg::t_dp_sts   i_sts,
    output bse_pkg::t_dp_ctl   o_ctl
);
    typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE, S_TDRAIN} t_state;
    t_state r_state;
    logic   r_trim_req;
    logic   r_trim_run;     // current sweep is a trim pass, no result

    always_comb begin
        o_ctl.load = 1'b0;
        o_ctl.trim = 1'b0;
        o_ctl.step = 1'b0;
        o_cmd_ready = (r_state == S_IDLE) && !r_trim_req;
        if (r_state == S_IDLE) begin
            o_ctl.load = r_trim_req || i_cmd_valid;
            o_ctl.trim = r_trim_req;
        end
        if (r_state == S_RUN) o_ctl.step = 1'b1;
        o_res_valid = (r_state == S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_trim_req <= 1'b0;
            r_trim_run <= 1'b0;
        end else begin
            if (i_cfg_we) r_trim_req <= 1'b1;
            case (r_state)
                S_IDLE: begin
                    if (r_trim_req) begin
                        r_state    <= S_RUN;
                        r_trim_run <= 1'b1;
                        if (!i_cfg_we) r_trim_req <= 1'b0;
                    end else if (i_cmd_valid) begin
                        r_state    <= S_RUN;
                        r_trim_run <= 1'b0;
                    end
                end
                S_RUN: if (i_sts.last_word) r_state <= r_trim_run ? S_TDRAIN : S_DRAIN;
                S_DRAIN: r_state <= S_DONE;
                S_TDRAIN: r_state <= S_IDLE;
                S_DONE: if (i_res_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/bitmap_scan_engine_unit.sv
`timescale 1ns / 1ps
// Flow: an accepted command is loaded in S_IDLE, then S_RUN sweeps all words through
//   the single-port-write RAM, one word per cycle, then S_DRAIN; the result is held in
//   S_DONE until taken, and no new command is accepted before then.
// Reset: synchronous active low; bitmap reads as zeros via per-word valid bits,
//   bit_count = 1024. A count write triggers a trim sweep over all words.
`include "bitmap_scan_engine_unit_macros.svh"
module bitmap_scan_engine_unit #(
    parameter int MaxBits  = bse_pkg::MaxBitsDef,
    parameter int WordBits = bse_pkg::WordBitsDef
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bse_cmd_if.sink                    cmd,
    bse_res_if.source                  res,
    input  logic                       i_cfg_we,
    input  logic [bse_pkg::CountW-1:0] i_cfg_data
);
    logic [bse_pkg::CountW-1:0] r_count;
    bse_pkg::t_dp_ctl w_ctl;
    bse_pkg::t_dp_sts w_sts;
    logic w_clear_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= bse_pkg::CountW'(1024);
        else if (i_cfg_we) r_count <= i_cfg_data;
    end

    // clear-all resets every word's valid bit at command load
    assign w_clear_all = w_ctl.load && !w_ctl.trim &&
                         cmd.data.kind == bse_pkg::K_CLR_ALL;

    bse_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd.valid), .o_cmd_ready(cmd.ready),
        .i_cfg_we(i_cfg_we),
        .o_res_valid(res.valid), .i_res_ready(res.ready),
        .i_sts(w_sts), .o_ctl(w_ctl)
    );

    bse_dp #(.MaxBits(MaxBits), .WordBits(WordBits)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_ctl(w_ctl), .i_cmd(cmd.data), .i_count(r_count),
        .i_clear_all(w_clear_all), .o_sts(w_sts), .o_res(res.data)
    );

    // result and command never overlap
    `BSE_ASSERT_IMPL(a_excl, i_clk, i_rst_n, !(res.valid && cmd.ready), "overlap")
    // a command accept starts a sweep with no result next cycle
    `BSE_ASSERT_NEXT(a_start, i_clk, i_rst_n, cmd.valid && cmd.ready, !res.valid, "early")
    // found implies no error
    `BSE_ASSERT_IMPL(a_found, i_clk, i_rst_n, !(res.valid && res.data.found && res.data.error),
        "found+err")
endmodule
